// ===== rtl/kcg_pkg.sv =====
// Shared types, codes and helpers for the k-combination generator.
package kcg_pkg;

  localparam int unsigned VAL_W     = 7;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned SET_W     = 7;
  localparam int unsigned SUB_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  localparam logic [VAL_W-1:0] VAL_MAX = 7'd127;

  // item opcodes
  localparam logic OPC_LOAD    = 1'b0;
  localparam logic OPC_ADVANCE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 2'd1;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] elem_index;
    logic [VAL_W-1:0] elem_value;
    logic             found;
    logic             last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFILL,
    ST_EMIT
  } state_t;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SCAN,
    OP_REFILL,
    OP_EMIT
  } dp_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic hit;
    logic ptr_zero;
    logic ptr_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = (v == VAL_MAX) ? VAL_MAX : v + VAL_W'(1);
    return r;
  endfunction

endpackage

// ===== rtl/kcg_ctrl.sv =====
// Controller state machine: takes loads and sequences scan, refill and emission of one advance.
module kcg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_opcode,
  output logic               in_stall,
  input  kcg_pkg::dp_status_t status,
  output kcg_pkg::dp_op_t     op
);
  import kcg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OPC_ADVANCE) begin
            op         = OP_START;
            state_next = ST_SCAN;
          end else begin
            op = OP_LOAD;
          end
        end
      end
      ST_SCAN: begin
        op = OP_SCAN;
        if (status.hit) begin
          state_next = ST_REFILL;
        end else if (status.ptr_zero) begin
          state_next = ST_EMIT;
        end
      end
      ST_REFILL: begin
        op = OP_REFILL;
        if (status.ptr_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        op = OP_EMIT;
        if (status.out_free && status.ptr_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/kcg_dp.sv =====
// Datapath: combination store, config registers, scan pointer and output register.
module kcg_dp #(
  parameter int unsigned MAX_K = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  kcg_pkg::dp_op_t                    op,
  output kcg_pkg::dp_status_t                status,
  input  kcg_pkg::in_t                       in_data,
  input  logic                               cfg_valid,
  input  logic [kcg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kcg_pkg::CFG_DAT_W-1:0]      cfg_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output kcg_pkg::out_t                      out_data
);
  import kcg_pkg::*;

  localparam int unsigned IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KW    = $clog2(MAX_K + 1);

  logic [VAL_W-1:0] comb [MAX_K];
  logic [SET_W-1:0] set_size;
  logic [SUB_W-1:0] subset_size;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] gap;
  logic [VAL_W-1:0] prev;
  logic             found;

  logic [KW-1:0]    k_act;
  logic [IDX_W-1:0] k_last;
  logic [VAL_W-1:0] cur;
  logic [VAL_W-1:0] cur_inc;
  logic [VAL_W-1:0] prev_inc;
  logic [7:0]       bound_sum;
  logic             hit;
  logic             out_free;
  logic             load_ok;

  // active K: zero acts as one, clamp to MAX_K
  always_comb begin
    if (subset_size == '0) begin
      k_act = KW'(1);
    end else if ({1'b0, subset_size} > (SUB_W + 1)'(MAX_K)) begin
      k_act = KW'(MAX_K);
    end else begin
      k_act = KW'(subset_size);
    end
  end

  assign k_last    = IDX_W'(k_act - KW'(1));
  assign cur       = comb[ptr];
  assign cur_inc   = sat_inc(cur);
  assign prev_inc  = sat_inc(prev);
  // v < N - gap  <=>  v + gap < N for nonnegative values
  assign bound_sum = 8'(cur_inc) + 8'(gap);
  assign hit       = (bound_sum < {1'b0, set_size});
  assign out_free  = !out_valid || !out_stall;
  assign load_ok   = (32'(in_data.position) < MAX_K);

  assign status.hit      = hit;
  assign status.ptr_zero = (ptr == '0);
  assign status.ptr_last = (ptr == k_last);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_K; i++) begin
        comb[i] <= '0;
      end
      set_size    <= SET_W'(8);
      subset_size <= SUB_W'(3);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_SET_SIZE) begin
          set_size <= cfg_data;
        end else if (cfg_index == CFG_SUBSET_SIZE) begin
          subset_size <= cfg_data[SUB_W-1:0];
        end
      end

      if (op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (op)
        OP_LOAD: begin
          if (load_ok) begin
            comb[IDX_W'(in_data.position)] <= in_data.value;
          end
        end
        OP_START: begin
          ptr <= k_last;
          gap <= '0;
        end
        OP_SCAN: begin
          comb[ptr] <= cur_inc;
          if (hit) begin
            found <= 1'b1;
            prev  <= cur_inc;
          end else if (ptr == '0) begin
            found <= 1'b0;
          end else begin
            ptr <= ptr - IDX_W'(1);
            gap <= gap + IDX_W'(1);
          end
        end
        OP_REFILL: begin
          if (ptr == k_last) begin
            ptr <= '0;
          end else begin
            comb[ptr + IDX_W'(1)] <= prev_inc;
            prev                  <= prev_inc;
            ptr                   <= ptr + IDX_W'(1);
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            out_data.elem_index <= POS_W'(ptr);
            out_data.elem_value <= cur;
            out_data.found      <= found;
            out_data.last       <= (ptr == k_last);
            if (ptr != k_last) begin
              ptr <= ptr + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/k_combination_generator.sv =====
// Top level of the k-combination generator: controller plus datapath.
// Usage
//   Input channel (in_valid/in_stall/in_data) takes load and advance items.
//   A load writes one element of the stored combination in the transfer
//   cycle and gives no result; the next item can follow right away.
//   An advance steps the combination to the next k-subset of {0..N-1} in
//   lexicographic order and emits K results on out_valid/out_data, one per
//   element in position order, with last set on the final one and found
//   clear when the combinations were exhausted.
//   An advance runs a start step, then a backward scan from the last position,
//   one position per cycle through the increment/compare unit, then, if a
//   position passed, a refill of the tail (its last step only rewinds the
//   pointer), then emission, one element per cycle while the output does not
//   stall; the next item is taken once the last element sits in the output
//   register.
//   A stall on the output holds the output register and pauses emission;
//   in_stall stays high until the last element has entered the output register.
//   Config writes (cfg_valid/cfg_ready, always ready) set N (index 0) and
//   K (index 1); they are meant for idle periods only.
//   Synchronous reset clears the store, sets N=8, K=3, drops any pending result.
module k_combination_generator #(
  parameter int unsigned MAX_K = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kcg_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kcg_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcg_pkg::CFG_DAT_W-1:0] cfg_data
);
  import kcg_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // registers are plain flops, a write always lands
  assign cfg_ready = 1'b1;

  kcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .status    (status),
    .op        (op)
  );

  kcg_dp #(
    .MAX_K (MAX_K)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb_k_combination_generator.sv =====
// Self-checking testbench for the k-combination generator: directed table, then random phases.
module tb_k_combination_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import kcg_pkg::*;

  localparam int MAX_K           = 8;
  // Far beyond the slowest legal run (about 200 items, 8 elements each, heavy stall).
  localparam int CYCLE_LIMIT     = 400000;
  // Quiet time after the last expected element; covers a full advance plus margin.
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 16;

  // The register map only defines indexes 0 and 1; the rest must be harmless.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // One line of the directed table: an item, or a register write.
  // When known is set, the three elements of a K=3 advance are given by hand.
  typedef struct packed {
    row_kind_t             kind;
    in_t                   item;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DAT_W-1:0]  dat;
    logic                  known;
    logic [VAL_W-1:0]      e0;
    logic [VAL_W-1:0]      e1;
    logic [VAL_W-1:0]      e2;
    logic                  ok;
  } row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  k_combination_generator #(
    .MAX_K(MAX_K)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: stored combination plus N and K.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] combo [MAX_K];
  logic [SET_W-1:0] set_n;
  logic [SUB_W-1:0] sub_k;
  out_t             step_elems [MAX_K];   // elements produced by the last advance
  out_t             elems_due [$];        // elements still to come out, oldest first

  // Hand-typed expectation for the item currently on the input channel.
  row_t             typed_row = '0;

  int idle_pct  = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int errors    = 0;
  int n_loads   = 0;
  int n_adv     = 0;
  int n_dead    = 0;   // advances that found no next combination
  int n_checked = 0;
  int n_writes  = 0;

  // Appends one element at the tail of the expected-element queue.
  function automatic void queue_elem(input out_t e);
    elems_due.insert(elems_due.size(), e);
  endfunction

  function automatic logic [VAL_W-1:0] bump_sat(input logic [VAL_W-1:0] v);
    return (v == VAL_MAX) ? VAL_MAX : v + 1'b1;
  endfunction

  // K as the block uses it: 0 reads as 1, anything above MAX_K as MAX_K.
  function automatic int eff_k(input logic [SUB_W-1:0] k);
    if (k < 1) return 1;
    if (k > MAX_K) return MAX_K;
    return int'(k);
  endfunction

  // Steps combo to the next k-subset; fills step_elems, returns the element count.
  function automatic int next_combination();
    int   k, pos, gap, hit, i;
    logic hit_ok;
    k      = eff_k(sub_k);
    pos    = k - 1;
    gap    = 0;
    hit    = 0;
    hit_ok = 1'b0;
    // Backward scan: bump each element until one stays below N - distance.
    // The bound is signed, so N at or below the distance never passes.
    while (pos >= 0 && !hit_ok) begin
      combo[pos] = bump_sat(combo[pos]);
      if (int'(combo[pos]) < int'(set_n) - gap) begin
        hit_ok = 1'b1;
        hit    = pos;
      end
      pos--;
      gap++;
    end
    // Refill the tail as a run of consecutive values; exhausted leaves the bumps as they are.
    if (hit_ok) begin
      for (i = hit; i < k - 1; i++) combo[i+1] = bump_sat(combo[i]);
    end else begin
      n_dead++;
    end
    for (i = 0; i < k; i++) begin
      step_elems[i].elem_index = POS_W'(i);
      step_elems[i].elem_value = combo[i];
      step_elems[i].found      = hit_ok;
      step_elems[i].last       = (i == k - 1);
    end
    return k;
  endfunction

  function automatic string fmt_elem(input out_t e);
    return $sformatf("idx=%0d val=%0d found=%0b last=%0b",
                     e.elem_index, e.elem_value, e.found, e.last);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts at each input transfer, checks each output transfer.
  // Everything is sampled at the rising edge; the DUT updates after it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_t want;
    int   n, i;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OPC_LOAD) begin
          // Loads past MAX_K are dropped; with a 3-bit position none are.
          if (int'(in_data.position) < MAX_K) combo[in_data.position] = in_data.value;
          n_loads++;
        end else begin
          n = next_combination();
          n_adv++;
          if (typed_row.known) begin
            queue_elem(out_t'{3'd0, typed_row.e0, typed_row.ok, 1'b0});
            queue_elem(out_t'{3'd1, typed_row.e1, typed_row.ok, 1'b0});
            queue_elem(out_t'{3'd2, typed_row.e2, typed_row.ok, 1'b1});
          end else begin
            for (i = 0; i < n; i++) queue_elem(step_elems[i]);
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (elems_due.size() == 0) begin
          note_error({"unexpected element ", fmt_elem(out_data)});
        end else begin
          want = elems_due.pop_front();
          n_checked++;
          if (out_data.elem_index !== want.elem_index ||
              out_data.elem_value !== want.elem_value ||
              out_data.found      !== want.found      ||
              out_data.last       !== want.last) begin
            note_error({"expected ", fmt_elem(want), ", got ", fmt_elem(out_data)});
          end
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one item, with random sender gaps first, and holds it until transfer.
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drops valid, lets every expected element out, then gives a trailing load time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (elems_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SET_SIZE) set_n = dat;
    else if (idx == CFG_SUBSET_SIZE) sub_k = dat[SUB_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Directed table rows
  function automatic row_t row_load(input int pos, input int val);
    row_t r;
    r               = '0;
    r.kind          = ROW_ITEM;
    r.item.opcode   = OPC_LOAD;
    r.item.position = POS_W'(pos);
    r.item.value    = VAL_W'(val);
    return r;
  endfunction

  function automatic row_t row_adv();
    row_t r;
    r             = '0;
    r.kind        = ROW_ITEM;
    r.item.opcode = OPC_ADVANCE;
    return r;
  endfunction

  function automatic row_t row_adv_known(input int v0, input int v1, input int v2, input bit f);
    row_t r;
    r       = row_adv();
    r.known = 1'b1;
    r.e0    = VAL_W'(v0);
    r.e1    = VAL_W'(v1);
    r.e2    = VAL_W'(v2);
    r.ok    = f;
    return r;
  endfunction

  function automatic row_t row_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.dat  = CFG_DAT_W'(val);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t steps [$];
    int   ph, i, k, v, lo, sent, nsel, ksel;

    // shadow state after reset: N=8, K=3, store cleared
    set_n = SET_W'(8);
    sub_k = SUB_W'(3);
    for (i = 0; i < MAX_K; i++) combo[i] = '0;

    // Rows with hand-typed elements run at the reset setting (N=8, K=3).
    steps = {
      row_adv_known(0, 0, 1, 1'b1),                       // first step from reset
      row_load(0, 5), row_load(1, 6), row_load(2, 7),
      row_adv_known(6, 7, 8, 1'b0),                       // last subset: exhausted
      row_load(0, 0), row_load(1, 1), row_load(2, 127),
      row_adv_known(0, 2, 3, 1'b1),                       // tail pinned at 127, refill
      row_load(0, 127), row_load(1, 127), row_load(2, 127),
      row_adv_known(127, 127, 127, 1'b0),                 // saturation everywhere
      row_load(7, 64), row_load(6, 0), row_load(5, 100), row_load(3, 64),  // beyond K
      row_load(0, 0), row_load(1, 1), row_load(2, 2),
      row_adv_known(0, 1, 3, 1'b1),
      row_reg(CFG_SUBSET_SIZE, 15), row_adv(),            // K above MAX_K, stale tail in play
      row_reg(CFG_SET_SIZE, 0), row_adv(),                // N zero: nothing passes
      row_reg(CFG_SET_SIZE, 127), row_reg(CFG_SUBSET_SIZE, 0), row_adv(),  // K zero acts as 1
      row_reg(CFG_UNUSED_2, 127), row_reg(CFG_UNUSED_3, 42), row_adv()     // no effect
    };

    // synchronous reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: back to back, no idling.
    foreach (steps[s]) begin
      typed_row = steps[s];
      if (steps[s].kind == ROW_CFG) begin
        wait_idle();
        write_reg(steps[s].idx, steps[s].dat);
      end else begin
        send_item(steps[s].item);
      end
    end
    typed_row = '0;

    // Random phases: each one picks a setting and an idling pattern.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 14;
          stall_pct = 14;
        end
      endcase
      case (ph)
        0: begin             // smallest: a single subset of one
          nsel = 1;
          ksel = 1;
        end
        1: begin
          nsel = 64;
          ksel = 8;
        end
        2: begin             // N == K: only one subset exists
          nsel = 8;
          ksel = 8;
        end
        3: begin             // widest register values
          nsel = 127;
          ksel = 15;
        end
        default: begin
          nsel = $urandom_range(24, 2);
          ksel = $urandom_range(8, 1);
        end
      endcase
      write_reg(CFG_SET_SIZE, CFG_DAT_W'(nsel));
      write_reg(CFG_SUBSET_SIZE, CFG_DAT_W'(ksel));
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_3, CFG_DAT_W'($urandom_range(127)));

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        k = eff_k(sub_k);
        if ($urandom_range(99) < 70 && int'(set_n) >= k) begin
          // Well-formed: load a valid ascending subset, then walk it forward.
          lo = 0;
          for (i = 0; i < k; i++) begin
            v = $urandom_range(int'(set_n) - k + i, lo);
            send_item(row_load(i, v).item);
            lo = v + 1;
            sent++;
          end
          // now and then park junk past K; it shows up if K grows later
          if (k < MAX_K && $urandom_range(4) == 0) begin
            send_item(row_load($urandom_range(MAX_K - 1, k), $urandom_range(127)).item);
            sent++;
          end
          repeat ($urandom_range(6, 1)) begin
            send_item(row_adv().item);
            sent++;
          end
        end else if ($urandom_range(1) == 0) begin
          // noise: any position, any 7-bit value
          send_item(row_load($urandom_range(MAX_K - 1), $urandom_range(127)).item);
          sent++;
        end else begin
          send_item(row_adv().item);
          sent++;
        end
      end
    end

    wait_idle();

    $display("Covered %0d loads and %0d advances (%0d exhausted), %0d register writes.",
             n_loads, n_adv, n_dead, n_writes);
    $display("Checked %0d combination elements; %0d errors.", n_checked, errors);
    if (errors == 0) begin
      $display("tb_k_combination_generator: PASS");
    end else begin
      $display("tb_k_combination_generator: FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost element ends here.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d elements still expected.",
             CYCLE_LIMIT, elems_due.size());
    $display("tb_k_combination_generator: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kcg_pkg.sv
rtl/kcg_ctrl.sv
rtl/kcg_dp.sv
rtl/k_combination_generator.sv
tb/sv/tb_k_combination_generator.sv
